// ===== src/rrlk_pkg.sv =====
// Shared types, codes and sizes for the ring record log keeper.
package rrlk_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

    localparam logic [31:0] SIGNATURE_RESET = 32'hA5A5_A5A5;

    // Stored slot contents.
    typedef struct packed {
        logic [63:0] payload_high;  // yaw | pitch << 32
        logic [63:0] payload_low;   // motor | generator << 32
        logic [31:0] signature;
        logic [31:0] record_id;
    } record_t;

    localparam int RECORD_W = $bits(record_t);

    typedef enum logic [1:0] {
        OP_RECOVER = 2'd0,
        OP_APPEND  = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STS_FOUND     = 3'd0,
        STS_NONE      = 3'd1,
        STS_WRITTEN   = 3'd2,
        STS_UNCHANGED = 3'd3,
        STS_SLOT_READ = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_CHECK
    } state_t;

endpackage

// ===== src/ring_record_log_keeper_core.sv =====
// Ring record log keeper: top level with command FSM, latest-record state and output register.
// Recover reads one slot per cycle from the single read port of the slot RAM.
// Throughput: one item at a time; the next item can be taken in the cycle after the result is
//   loaded, while that result may still wait in the output register.
// Reset (rst_n low, asynchronous): FSM idle, output empty, latest record and current slot
//   zero, every slot reads as erased (all zero), signature register 0xA5A5A5A5.
module ring_record_log_keeper_core
    import rrlk_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,

    // Configuration: valid signature word
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data,

    // Command items
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [3:0] slot_index, [35:4] motor_seconds, [67:36] generator_rotations,
    // [99:68] yaw_commands, [131:100] pitch_commands, [135:132] zero
    input  logic [135:0] s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]   s_axis_tuser,

    // Result items
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [3:0] out_slot, [35:4] out_record_id, [67:36] out_motor_seconds,
    // [99:68] out_generator_rotations, [131:100] out_yaw_commands,
    // [163:132] out_pitch_commands, [167:164] zero
    output logic [167:0] m_axis_tdata,
    // [2:0] status, [3] signature_ok
    output logic [3:0]   m_axis_tuser
);

    // ------------------------------------------------------------------
    // Configuration register. User must write it only while the block is idle; not enforced.
    // ------------------------------------------------------------------
    logic [31:0] signature_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signature_reg <= SIGNATURE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            signature_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // State and registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    // Captured item
    op_t               op_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [63:0]       in_low_reg;
    logic [63:0]       in_high_reg;

    // Latest record and ring position
    logic [31:0]       latest_id_reg;
    logic [63:0]       latest_low_reg;
    logic [63:0]       latest_high_reg;
    logic [SLOT_W-1:0] current_slot_reg;

    // Recovery scan
    logic [SLOT_W-1:0] scan_cnt_reg;
    logic              best_found_reg;
    logic [31:0]       best_id_reg;
    logic [SLOT_W-1:0] best_slot_reg;
    logic [63:0]       best_low_reg;
    logic [63:0]       best_high_reg;

    // Output register
    logic              out_valid_reg;
    status_t           out_status_reg;
    logic              out_sig_ok_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [31:0]       out_id_reg;
    logic [63:0]       out_low_reg;
    logic [63:0]       out_high_reg;

    // ------------------------------------------------------------------
    // Slot store
    // ------------------------------------------------------------------
    logic [SLOT_W-1:0] rd_addr;
    record_t           rd_rec;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    record_t           wr_rec;

    rrlk_slot_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_rec),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_rec)
    );

    // ------------------------------------------------------------------
    // Decode of the incoming item and the slot under inspection
    // ------------------------------------------------------------------
    logic        in_accept;
    op_t         in_op;
    logic        out_free;
    logic        out_load;
    logic        rd_sig_ok;
    logic        scan_hit;
    logic        payload_same;
    logic [SLOT_W-1:0] next_slot;
    logic [31:0] next_id;

    assign in_op     = op_t'(s_axis_tuser);
    assign in_accept = s_axis_tvalid && s_axis_tready;
    // The output register may be loaded when empty or emptying this cycle.
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign out_load  = ((state_reg == ST_FINISH) || (state_reg == ST_CHECK)) && out_free;

    assign rd_sig_ok    = (rd_rec.signature == signature_reg);
    // Ties go to the later slot, hence >=.
    assign scan_hit     = rd_sig_ok && (rd_rec.record_id >= best_id_reg);
    assign payload_same = (in_low_reg == latest_low_reg) && (in_high_reg == latest_high_reg);
    assign next_slot    = (current_slot_reg == SLOT_LAST) ? '0 : current_slot_reg + 1'b1;
    assign next_id      = latest_id_reg + 32'd1;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (in_op)
                        OP_RECOVER: state_next = ST_SCAN;
                        OP_APPEND,
                        OP_READ:    state_next = ST_CHECK;
                        OP_NONE:    state_next = ST_IDLE;   // drop silently
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == SLOT_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH,
            ST_CHECK:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Memory control
    // ------------------------------------------------------------------
    always_comb
    begin
        rd_addr = current_slot_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // Prime the first read so data is ready in the next state.
                unique case (in_op)
                    OP_RECOVER: rd_addr = '0;
                    OP_APPEND:  rd_addr = current_slot_reg;
                    OP_READ:    rd_addr = s_axis_tdata[SLOT_W-1:0];
                    OP_NONE:    rd_addr = current_slot_reg;
                endcase
            end
            ST_SCAN:
            begin
                rd_addr = scan_cnt_reg + 1'b1;
            end
            ST_CHECK:
            begin
                // Keep re-reading the same slot while the result stalls.
                rd_addr = (op_reg == OP_READ) ? idx_reg : current_slot_reg;
            end
            default:
            begin
                rd_addr = current_slot_reg;
            end
        endcase
    end

    assign wr_en   = (state_reg == ST_CHECK) && (op_reg == OP_APPEND) && out_free
                     && !payload_same;
    assign wr_addr = next_slot;

    always_comb
    begin
        wr_rec              = '0;
        wr_rec.record_id    = next_id;
        wr_rec.signature    = signature_reg;
        wr_rec.payload_low  = in_low_reg;
        wr_rec.payload_high = in_high_reg;
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            latest_id_reg    <= '0;
            latest_low_reg   <= '0;
            latest_high_reg  <= '0;
            current_slot_reg <= '0;
            scan_cnt_reg     <= '0;
            best_found_reg   <= 1'b0;
            op_reg           <= OP_NONE;
        end
        else
        begin
            state_reg <= state_next;

            // Hold the result until taken; load a fresh one as the old one leaves.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        op_reg         <= in_op;
                        scan_cnt_reg   <= '0;
                        best_found_reg <= 1'b0;
                    end
                end
                ST_SCAN:
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    if (scan_hit)
                    begin
                        best_found_reg <= 1'b1;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        // Adopt the best slot; otherwise hold the old latest record.
                        if (best_found_reg)
                        begin
                            current_slot_reg <= best_slot_reg;
                            latest_id_reg    <= best_id_reg;
                            latest_low_reg   <= best_low_reg;
                            latest_high_reg  <= best_high_reg;
                        end
                    end
                end
                ST_CHECK:
                begin
                    if (out_free)
                    begin
                        if (wr_en)
                        begin
                            current_slot_reg <= next_slot;
                            latest_id_reg    <= next_id;
                            latest_low_reg   <= in_low_reg;
                            latest_high_reg  <= in_high_reg;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Payload registers (no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    idx_reg     <= s_axis_tdata[SLOT_W-1:0];
                    in_low_reg  <= s_axis_tdata[67:4];
                    in_high_reg <= s_axis_tdata[131:68];
                    best_id_reg <= '0;
                    best_slot_reg <= '0;
                end
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    best_id_reg   <= rd_rec.record_id;
                    best_slot_reg <= scan_cnt_reg;
                    best_low_reg  <= rd_rec.payload_low;
                    best_high_reg <= rd_rec.payload_high;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    // With no match every slot fails the signature check.
                    out_sig_ok_reg <= best_found_reg;
                    if (best_found_reg)
                    begin
                        out_status_reg <= STS_FOUND;
                        out_slot_reg   <= best_slot_reg;
                        out_id_reg     <= best_id_reg;
                        out_low_reg    <= best_low_reg;
                        out_high_reg   <= best_high_reg;
                    end
                    else
                    begin
                        out_status_reg <= STS_NONE;
                        out_slot_reg   <= current_slot_reg;
                        out_id_reg     <= latest_id_reg;
                        out_low_reg    <= latest_low_reg;
                        out_high_reg   <= latest_high_reg;
                    end
                end
            end
            ST_CHECK:
            begin
                if (out_free)
                begin
                    priority if (op_reg == OP_READ)
                    begin
                        out_status_reg <= STS_SLOT_READ;
                        out_sig_ok_reg <= rd_sig_ok;
                        out_slot_reg   <= idx_reg;
                        out_id_reg     <= rd_rec.record_id;
                        out_low_reg    <= rd_rec.payload_low;
                        out_high_reg   <= rd_rec.payload_high;
                    end
                    else if (payload_same)
                    begin
                        out_status_reg <= STS_UNCHANGED;
                        out_sig_ok_reg <= rd_sig_ok;
                        out_slot_reg   <= current_slot_reg;
                        out_id_reg     <= latest_id_reg;
                        out_low_reg    <= latest_low_reg;
                        out_high_reg   <= latest_high_reg;
                    end
                    else
                    begin
                        // Fresh record carries the current signature.
                        out_status_reg <= STS_WRITTEN;
                        out_sig_ok_reg <= 1'b1;
                        out_slot_reg   <= next_slot;
                        out_id_reg     <= next_id;
                        out_low_reg    <= in_low_reg;
                        out_high_reg   <= in_high_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign s_axis_tready = (state_reg == ST_IDLE);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_high_reg, out_low_reg, out_id_reg, 4'(out_slot_reg)};
    assign m_axis_tuser  = {out_sig_ok_reg, out_status_reg};

endmodule

// ===== src/rrlk_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module rrlk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/rrlk_slot_store.sv =====
// Slot store: record RAM plus per-slot written flags so erased slots read as zero.
module rrlk_slot_store
    import rrlk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] rd_addr,
    output record_t           rd_data,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  record_t           wr_data
);

    logic [SLOT_COUNT-1:0] written_reg;
    logic                  rd_written_reg;
    logic [RECORD_W-1:0]   ram_q;

    rrlk_ram #(
        .WIDTH (RECORD_W),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // Track which slots have ever been written; the rest read as erased.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            rd_written_reg <= written_reg[rd_addr];
        end
    end

    assign rd_data = rd_written_reg ? record_t'(ram_q) : '0;

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the ring record log keeper: directed and random commands against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import rrlk_pkg::*;

    // Cycles to let pass before a signature write, so that a recover can finish
    // even when the last item sent produced no reply.
    localparam int SETTLE_CYCLES = SLOT_COUNT + 8;
    localparam int PHASE_ITEMS   = 226;

    // One reply as the block returns it.
    typedef struct {
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       record_id;
        logic              sig_ok;
        logic [63:0]       lo;      // motor | generator << 32
        logic [63:0]       hi;      // yaw | pitch << 32
    } reply_t;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [31:0]    cfg_data;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [135:0]   s_axis_tdata;
    logic [1:0]     s_axis_tuser;
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [167:0]   m_axis_tdata;
    logic [3:0]     m_axis_tuser;

    // Predicted copy of the block's store and latest record
    logic [31:0]       ring_id  [SLOT_COUNT];
    logic [31:0]       ring_sig [SLOT_COUNT];
    logic [63:0]       ring_lo  [SLOT_COUNT];
    logic [63:0]       ring_hi  [SLOT_COUNT];
    logic [31:0]       last_id;
    logic [63:0]       last_lo;
    logic [63:0]       last_hi;
    logic [SLOT_W-1:0] cur_slot;
    logic [31:0]       signature_word;

    reply_t replies_due [$];
    int     errors;
    bit     source_idle;    // sender draws gaps
    bit     sink_idle;      // receiver draws stalls

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ring_record_log_keeper_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Work out the reply that one accepted command causes and update the predicted state.
    function automatic void apply_command(op_t op, logic [SLOT_W-1:0] idx,
                                          logic [63:0] lo, logic [63:0] hi);
        reply_t            r;
        logic              found;
        logic [31:0]       best_id;
        logic [SLOT_W-1:0] best_slot;
        int                i;
        case (op)
            OP_RECOVER:
            begin
                found     = 1'b0;
                best_id   = '0;
                best_slot = '0;
                // highest ID among matching slots, a tie goes to the later slot
                for (i = 0; i < SLOT_COUNT; i++)
                begin
                    if (ring_sig[i] == signature_word && ring_id[i] >= best_id)
                    begin
                        best_id   = ring_id[i];
                        best_slot = SLOT_W'(i);
                        found     = 1'b1;
                    end
                end
                if (found)
                begin
                    cur_slot = best_slot;
                    last_id  = best_id;
                    last_lo  = ring_lo[best_slot];
                    last_hi  = ring_hi[best_slot];
                end
                r.status    = found ? STS_FOUND : STS_NONE;
                r.slot      = cur_slot;
                r.record_id = last_id;
                r.lo        = last_lo;
                r.hi        = last_hi;
            end
            OP_APPEND:
            begin
                if (lo == last_lo && hi == last_hi)
                begin
                    r.status = STS_UNCHANGED;
                end
                else
                begin
                    // advance with wrap and stamp the next ID
                    cur_slot           = (cur_slot == SLOT_LAST) ? '0 : cur_slot + 1'b1;
                    last_id            = last_id + 32'd1;
                    last_lo            = lo;
                    last_hi            = hi;
                    ring_id[cur_slot]  = last_id;
                    ring_sig[cur_slot] = signature_word;
                    ring_lo[cur_slot]  = lo;
                    ring_hi[cur_slot]  = hi;
                    r.status           = STS_WRITTEN;
                end
                r.slot      = cur_slot;
                r.record_id = last_id;
                r.lo        = last_lo;
                r.hi        = last_hi;
            end
            OP_READ:
            begin
                r.status    = STS_SLOT_READ;
                r.slot      = idx;
                r.record_id = ring_id[idx];
                r.lo        = ring_lo[idx];
                r.hi        = ring_hi[idx];
            end
            default:
                return;     // ignored command, no reply
        endcase
        r.sig_ok = (ring_sig[r.slot] == signature_word);
        replies_due.push_back(r);
    endfunction

    // Boundary values now and then, random words otherwise.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Present one command, hold it until taken, then predict its reply.
    task automatic send_command(op_t op, logic [SLOT_W-1:0] idx,
                                logic [63:0] lo, logic [63:0] hi);
        int gap;
        gap = source_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0, hi[63:32], hi[31:0], lo[63:32], lo[31:0], idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        apply_command(op, idx, lo, hi);
    endtask

    // Drop the command valid, wait for every reply, then let a recover run out.
    task automatic wait_for_replies();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (replies_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the signature register; call only while the block is idle.
    task automatic write_signature(logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid      <= 1'b0;
        signature_word  = value;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    // Compare one accepted reply with the oldest prediction.
    task automatic check_reply();
        reply_t want;
        reply_t got;
        got.status    = status_t'(m_axis_tuser[2:0]);
        got.sig_ok    = m_axis_tuser[3];
        got.slot      = m_axis_tdata[3:0];
        got.record_id = m_axis_tdata[35:4];
        got.lo        = {m_axis_tdata[99:68], m_axis_tdata[67:36]};
        got.hi        = {m_axis_tdata[163:132], m_axis_tdata[131:100]};
        if (replies_due.size() == 0)
        begin
            errors++;
            $display("%0t: reply with none pending, expected nothing actual %h %h",
                     $time, m_axis_tuser, m_axis_tdata);
            return;
        end
        want = replies_due.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("out_slot", 32'(want.slot), 32'(got.slot));
        check_field("out_record_id", want.record_id, got.record_id);
        check_field("signature_ok", 32'(want.sig_ok), 32'(got.sig_ok));
        check_field("out_motor_seconds", want.lo[31:0], got.lo[31:0]);
        check_field("out_generator_rotations", want.lo[63:32], got.lo[63:32]);
        check_field("out_yaw_commands", want.hi[31:0], got.hi[31:0]);
        check_field("out_pitch_commands", want.hi[63:32], got.hi[63:32]);
    endtask

    // Erased store straight after reset: nothing valid, an all-zero append is unchanged.
    task automatic test_erased_store();
        send_command(OP_RECOVER, 4'd0, '0, '0);
        send_command(OP_READ, 4'd0, '0, '0);
        send_command(OP_READ, 4'd15, {64{1'b1}}, {64{1'b1}});
        send_command(OP_APPEND, 4'd7, '0, '0);
        send_command(OP_NONE, 4'd15, {64{1'b1}}, {64{1'b1}});
    endtask

    // Appends with extreme payloads, a repeat, reads of written and blank slots, recover.
    task automatic test_append_and_read();
        send_command(OP_APPEND, 4'd0, {64{1'b1}}, {64{1'b1}});
        send_command(OP_APPEND, 4'd0, {64{1'b1}}, {64{1'b1}});
        send_command(OP_APPEND, 4'd9, {32{2'b01}}, {32{2'b10}});
        send_command(OP_APPEND, 4'd6, '0, '0);
        send_command(OP_READ, 4'd1, '0, '0);
        send_command(OP_READ, 4'd3, '0, '0);
        send_command(OP_READ, 4'd4, '0, '0);
        send_command(OP_RECOVER, 4'd0, '0, '0);
        send_command(OP_NONE, 4'd0, '0, '0);
    endtask

    // A zero signature makes every erased slot valid, so recover breaks a tie of
    // ID zero towards the last slot; the reset word then brings the old records back.
    task automatic test_signature_extremes();
        wait_for_replies();
        write_signature(32'h0000_0000);
        send_command(OP_RECOVER, 4'd0, '0, '0);
        send_command(OP_APPEND, 4'd0, {2{32'h8000_0001}}, {2{32'h7FFF_FFFE}});
        send_command(OP_READ, 4'd0, '0, '0);
        send_command(OP_READ, 4'd2, '0, '0);
        wait_for_replies();
        write_signature(SIGNATURE_RESET);
        send_command(OP_RECOVER, 4'd0, '0, '0);
        send_command(OP_READ, 4'd0, '0, '0);
    endtask

    // Mostly appends, reads and recovers, with a few ignored commands mixed in.
    task automatic run_random_phase(logic [31:0] sig, bit gaps, bit stalls);
        int          n;
        int          pick;
        op_t         op;
        logic [63:0] lo;
        logic [63:0] hi;
        wait_for_replies();
        write_signature(sig);
        source_idle = gaps;
        sink_idle   = stalls;
        for (n = 0; n < PHASE_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                op = OP_APPEND;
            else if (pick < 70)
                op = OP_READ;
            else if (pick < 94)
                op = OP_RECOVER;
            else
                op = OP_NONE;
            lo = {pick_word(), pick_word()};
            hi = {pick_word(), pick_word()};
            // repeat the latest payload now and then to hit the unchanged path
            if (op == OP_APPEND && $urandom_range(0, 6) == 0)
            begin
                lo = last_lo;
                hi = last_hi;
            end
            send_command(op, SLOT_W'($urandom_range(0, SLOT_COUNT - 1)), lo, hi);
        end
    endtask

    // Phases with different signatures, so recover finds old and new records mixed.
    task automatic test_random_traffic();
        run_random_phase(32'hFFFF_FFFF, 1'b1, 1'b1);
        run_random_phase($urandom, 1'b0, 1'b0);
        run_random_phase(32'h0000_0000, 1'b1, 1'b0);
        run_random_phase(32'hFFFF_FFFF, 1'b0, 1'b1);
        run_random_phase(SIGNATURE_RESET, 1'b1, 1'b1);
    endtask

    // Receiver: stall at random, take each reply and check it.
    initial
    begin
        int stall;
        m_axis_tready <= 1'b0;
        forever
        begin
            stall = sink_idle ? $urandom_range(0, 8) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
            check_reply();
        end
    end

    initial
    begin
        int i;
        errors          = 0;
        source_idle     = 1'b1;
        sink_idle       = 1'b1;
        rst_n          <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_data       <= '0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tuser   <= OP_RECOVER;
        // erased store and reset register
        for (i = 0; i < SLOT_COUNT; i++)
        begin
            ring_id[i]  = '0;
            ring_sig[i] = '0;
            ring_lo[i]  = '0;
            ring_hi[i]  = '0;
        end
        last_id        = '0;
        last_lo        = '0;
        last_hi        = '0;
        cur_slot       = '0;
        signature_word = SIGNATURE_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_erased_store();
        test_append_and_read();
        test_signature_extremes();
        test_random_traffic();

        // drain, then give stray replies time to show up
        wait_for_replies();
        if (errors == 0 && replies_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rrlk_pkg.sv
src/rrlk_ram.sv
src/rrlk_slot_store.sv
src/ring_record_log_keeper_core.sv
tb/tb_top.sv
